// File: hdl/raster_write_scheduler_macros.svh
// assertion macros for the raster write scheduler
`ifndef RASTER_WRITE_SCHEDULER_MACROS_SVH
`define RASTER_WRITE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define RWS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rws assertion failed");

// next-cycle implication
`define RWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rws assertion failed");

`endif

// File: hdl/rws_pkg.sv
// shared types, constants and helpers of the raster write scheduler
package rws_pkg;

   localparam int LINE_W   = 9;
   localparam int CYC_W    = 7;
   localparam int TCYC_W   = 8;
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int POS_W    = 15;
   localparam int SUM_W    = 17;
   localparam int CNT_W    = 4;
   localparam int APB_W    = 32;
   localparam int PADDR_W  = 3;

   localparam logic [POS_W-1:0]  POS_MAX     = 15'h7fff;
   localparam logic [ADDR_W-1:0] BORDER_ADDR = 16'hd020;
   localparam logic [CYC_W-1:0]  SAFE_CYCLE  = 7'd55;
   localparam logic [LINE_W-1:0] BAD_LINE_LO = 9'd48;
   localparam logic [LINE_W-1:0] BAD_LINE_HI = 9'd247;
   localparam logic [TCYC_W-1:0] BAD_CYC_LO  = 8'd15;
   localparam logic [TCYC_W-1:0] BAD_CYC_HI  = 8'd54;
   localparam logic [2:0]        BAD_PHASE   = 3'd3;

   localparam logic [CYC_W-1:0]  CPL_RESET   = 7'd63;
   localparam logic [LINE_W-1:0] LPF_RESET   = 9'd312;

   localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(POS_W - 1);

   typedef struct packed {
      logic capture;
      logic calc;
      logic emit;
      logic div_step;
      logic fix;
   } rws_cmd_type;

   typedef struct packed {
      logic out_free;
   } rws_sts_type;

   function automatic logic in_bad_window(input logic [POS_W-1:0] line,
                                          input logic [TCYC_W-1:0] cyc);
      logic line_ok;
      logic cyc_ok;
      line_ok = (line >= POS_W'(BAD_LINE_LO)) && (line <= POS_W'(BAD_LINE_HI))
                && (line[2:0] == BAD_PHASE);
      cyc_ok  = (cyc >= BAD_CYC_LO) && (cyc <= BAD_CYC_HI);
      return line_ok && cyc_ok;
   endfunction

   function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
      return (v > SUM_W'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
   endfunction

endpackage

// File: hdl/rws_csr.sv
// configuration registers behind the apb-style port
module rws_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rws_pkg::PADDR_W-1:0]       paddr,
   input  logic [rws_pkg::APB_W-1:0]         pwdata,
   output logic [rws_pkg::APB_W-1:0]         prdata,
   output logic                              pready,
   output logic [rws_pkg::CYC_W-1:0]         cycles_per_line,
   output logic [rws_pkg::LINE_W-1:0]        lines_per_frame
);

   logic [rws_pkg::CYC_W-1:0]  cpl_ff, cpl_in;
   logic [rws_pkg::LINE_W-1:0] lpf_ff, lpf_in;
   logic                       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      cpl_in = cpl_ff;
      lpf_in = lpf_ff;
      if (wr_en) begin
         if (paddr[2]) begin
            lpf_in = pwdata[rws_pkg::LINE_W-1:0];
         end else begin
            cpl_in = pwdata[rws_pkg::CYC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff <= rws_pkg::CPL_RESET;
         lpf_ff <= rws_pkg::LPF_RESET;
      end else begin
         cpl_ff <= cpl_in;
         lpf_ff <= lpf_in;
      end
   end

   always_comb begin
      if (paddr[2]) begin
         prdata = rws_pkg::APB_W'(lpf_ff);
      end else begin
         prdata = rws_pkg::APB_W'(cpl_ff);
      end
   end

   assign cycles_per_line = cpl_ff;
   assign lines_per_frame = lpf_ff;

endmodule

// File: hdl/rws_ctrl.sv
// sequencing state machine of the raster write scheduler
module rws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rws_pkg::rws_sts_type sts,
   output rws_pkg::rws_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_EMIT = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIX  = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [rws_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.calc = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == rws_pkg::DIV_LAST) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: hdl/rws_dpath.sv
// clamp, target, wait decision, position divider and result register
module rws_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  rws_pkg::rws_cmd_type         cmd,
   output rws_pkg::rws_sts_type         sts,
   input  logic [rws_pkg::CYC_W-1:0]    cycles_per_line,
   input  logic [rws_pkg::LINE_W-1:0]   lines_per_frame,
   input  logic                         req_frame_start,
   input  logic [rws_pkg::LINE_W-1:0]   req_raster_line,
   input  logic [rws_pkg::TCYC_W-1:0]   req_target_cycle,
   input  logic [rws_pkg::ADDR_W-1:0]   req_reg_addr,
   input  logic [rws_pkg::DATA_W-1:0]   req_reg_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_wait_needed,
   output logic [rws_pkg::LINE_W-1:0]   rsp_wait_line,
   output logic [rws_pkg::CYC_W-1:0]    rsp_wait_cycle,
   output logic [rws_pkg::ADDR_W-1:0]   rsp_write_addr,
   output logic [rws_pkg::DATA_W-1:0]   rsp_write_data
);

   localparam int LW = rws_pkg::LINE_W;
   localparam int CW = rws_pkg::CYC_W;
   localparam int TW = rws_pkg::TCYC_W;
   localparam int PW = rws_pkg::POS_W;
   localparam int SW = rws_pkg::SUM_W;
   localparam int AW = rws_pkg::ADDR_W;
   localparam int DW = rws_pkg::DATA_W;

   logic [LW-1:0] line_ff, line_in;
   logic [CW-1:0] cyc_ff, cyc_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [DW-1:0] val_ff, val_in;
   logic          fs_ff, fs_in;
   logic [PW-1:0] tgt_ff, tgt_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          known_ff, known_in;
   logic [PW-1:0] dq_ff, dq_in;
   logic [CW-1:0] rem_ff, rem_in;

   logic          ov_ff, ov_in;
   logic          owait_ff, owait_in;
   logic [LW-1:0] oline_ff, oline_in;
   logic [CW-1:0] ocyc_ff, ocyc_in;
   logic [AW-1:0] oaddr_ff, oaddr_in;
   logic [DW-1:0] odata_ff, odata_in;

   logic [CW-1:0] cpl;
   logic [LW-1:0] line_c;
   logic [TW-1:0] cyc_lo;
   logic [CW-1:0] cyc_c;
   logic [CW-1:0] cyc_adj;
   logic [LW-1:0] mul_a;
   logic [SW-1:0] mul_p;
   logic [SW-1:0] mul_add;
   logic [PW-1:0] mul_sat;
   logic          wait_now;
   logic [PW-1:0] pos_sel;
   logic [PW-1:0] pos_inc;
   logic [CW:0]   div_sh;
   logic          div_ge;
   logic [TW-1:0] fix_cyc;
   logic          fix_bad;

   assign cpl = (cycles_per_line == '0) ? CW'(1) : cycles_per_line;

   // clamp and bad-line adjust of the incoming target
   always_comb begin
      if (lines_per_frame == '0) begin
         line_c = '0;
      end else if (req_raster_line >= lines_per_frame) begin
         line_c = lines_per_frame - 1'b1;
      end else begin
         line_c = req_raster_line;
      end
      cyc_lo = (req_target_cycle == '0) ? TW'(1) : req_target_cycle;
      cyc_c  = (cyc_lo > TW'(cpl)) ? cpl : cyc_lo[CW-1:0];
      if (rws_pkg::in_bad_window(PW'(line_c), TW'(cyc_c))) begin
         cyc_adj = rws_pkg::SAFE_CYCLE;
      end else begin
         cyc_adj = cyc_c;
      end
   end

   // shared multiplier: target in calc, safe position in fix
   always_comb begin
      if (cmd.fix) begin
         mul_a   = dq_ff[LW-1:0];
         mul_add = SW'(rws_pkg::SAFE_CYCLE) - 1'b1;
      end else begin
         mul_a   = line_ff;
         mul_add = SW'(cyc_ff) - 1'b1;
      end
      mul_p   = SW'(mul_a) * SW'(cpl);
      mul_sat = rws_pkg::sat_pos(mul_p + mul_add);
   end

   assign wait_now = !(known_ff & ~fs_ff) || (tgt_ff > pos_ff);
   assign pos_sel  = wait_now ? tgt_ff : pos_ff;
   assign pos_inc  = rws_pkg::sat_pos(SW'(pos_sel) + 1'b1);

   assign div_sh   = {rem_ff, dq_ff[PW-1]};
   assign div_ge   = div_sh >= (CW+1)'(cpl);
   assign fix_cyc  = TW'(rem_ff) + 1'b1;
   assign fix_bad  = rws_pkg::in_bad_window(dq_ff, fix_cyc);

   assign sts.out_free = !ov_ff || rsp_ready;

   always_comb begin
      line_in  = line_ff;
      cyc_in   = cyc_ff;
      addr_in  = addr_ff;
      val_in   = val_ff;
      fs_in    = fs_ff;
      tgt_in   = tgt_ff;
      pos_in   = pos_ff;
      known_in = known_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      ov_in    = ov_ff & ~rsp_ready;
      owait_in = owait_ff;
      oline_in = oline_ff;
      ocyc_in  = ocyc_ff;
      oaddr_in = oaddr_ff;
      odata_in = odata_ff;
      if (cmd.capture) begin
         line_in = line_c;
         cyc_in  = cyc_adj;
         addr_in = req_reg_addr;
         val_in  = req_reg_value;
         fs_in   = req_frame_start;
      end
      if (cmd.calc) begin
         tgt_in = mul_sat;
      end
      if (cmd.emit) begin
         ov_in    = 1'b1;
         owait_in = wait_now;
         oline_in = line_ff;
         ocyc_in  = cyc_ff;
         oaddr_in = addr_ff;
         if (addr_ff == rws_pkg::BORDER_ADDR) begin
            odata_in = DW'(val_ff == '0);
         end else begin
            odata_in = val_ff;
         end
         known_in = 1'b1;
         pos_in   = pos_inc;
         dq_in    = pos_inc;
         rem_in   = '0;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = CW'(div_sh - (CW+1)'(cpl));
         end else begin
            rem_in = div_sh[CW-1:0];
         end
         dq_in = {dq_ff[PW-2:0], div_ge};
      end
      if (cmd.fix && fix_bad) begin
         pos_in = mul_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         known_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         known_ff <= known_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff  <= line_in;
      cyc_ff   <= cyc_in;
      addr_ff  <= addr_in;
      val_ff   <= val_in;
      fs_ff    <= fs_in;
      tgt_ff   <= tgt_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      owait_ff <= owait_in;
      oline_ff <= oline_in;
      ocyc_ff  <= ocyc_in;
      oaddr_ff <= oaddr_in;
      odata_ff <= odata_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_wait_needed = owait_ff;
   assign rsp_wait_line   = oline_ff;
   assign rsp_wait_cycle  = ocyc_ff;
   assign rsp_write_addr  = oaddr_ff;
   assign rsp_write_data  = odata_ff;

endmodule

// File: hdl/raster_write_scheduler.sv
// top level of the raster write scheduler
//
// channel  role      signals
// req      in beat   req_valid/req_ready, frame_start, line, cycle, addr, value
// rsp      out beat  rsp_valid/rsp_ready, wait flag, line, cycle, addr, data
// csr      config    psel/penable/pwrite/paddr/pwdata/prdata/pready
//
// one beat at a time: capture, multiply, emit, 15 divider steps and a bad-line
// fix; no new request is taken until the fix step is done and the block is idle
// the result beat is registered at the emit step, after capture and multiply
// a held result stalls the next beat only at its own emit step
// synchronous active-high reset; position unknown after reset
`include "raster_write_scheduler_macros.svh"

module raster_write_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_frame_start,
   input  logic [rws_pkg::LINE_W-1:0]        req_raster_line,
   input  logic [rws_pkg::TCYC_W-1:0]        req_target_cycle,
   input  logic [rws_pkg::ADDR_W-1:0]        req_reg_addr,
   input  logic [rws_pkg::DATA_W-1:0]        req_reg_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_wait_needed,
   output logic [rws_pkg::LINE_W-1:0]        rsp_wait_line,
   output logic [rws_pkg::CYC_W-1:0]         rsp_wait_cycle,
   output logic [rws_pkg::ADDR_W-1:0]        rsp_write_addr,
   output logic [rws_pkg::DATA_W-1:0]        rsp_write_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rws_pkg::PADDR_W-1:0]       paddr,
   input  logic [rws_pkg::APB_W-1:0]         pwdata,
   output logic [rws_pkg::APB_W-1:0]         prdata,
   output logic                              pready
);

   rws_pkg::rws_cmd_type       cmd;
   rws_pkg::rws_sts_type       sts;
   logic [rws_pkg::CYC_W-1:0]  cycles_per_line;
   logic [rws_pkg::LINE_W-1:0] lines_per_frame;

   rws_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .cycles_per_line (cycles_per_line),
      .lines_per_frame (lines_per_frame)
   );

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rws_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cycles_per_line  (cycles_per_line),
      .lines_per_frame  (lines_per_frame),
      .req_frame_start  (req_frame_start),
      .req_raster_line  (req_raster_line),
      .req_target_cycle (req_target_cycle),
      .req_reg_addr     (req_reg_addr),
      .req_reg_value    (req_reg_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wait_needed  (rsp_wait_needed),
      .rsp_wait_line    (rsp_wait_line),
      .rsp_wait_cycle   (rsp_wait_cycle),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_write_data   (rsp_write_data)
   );

   `RWS_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `RWS_ASSERT_NEXT(a_accept_calc, clock, reset, req_valid && req_ready, cmd.calc)
   `RWS_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, sts.out_free)
   `RWS_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid)

endmodule
